/* src/scs_pkg.sv */
// Shared types, constants and the reciprocal table for the sine/cosine series block.
// No dependencies; imported by every module of the block except scs_checker.
`default_nettype none

package scs_pkg;

    localparam int NUM_TERMS = 10;
    localparam int N_W       = $clog2(NUM_TERMS);
    localparam int K_W       = $clog2(2 * NUM_TERMS);

    localparam int NUM_STEPS = 16;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    localparam logic signed [63:0] PI_Q56     = 64'sh0324_3F6A_8885_A309;
    localparam logic signed [63:0] TWO_PI_Q56 = 64'sh0648_7ED5_110B_4612;
    localparam logic signed [63:0] NEG_PI_Q56 = -PI_Q56;
    localparam logic signed [63:0] ONE_Q59    = 64'sh0800_0000_0000_0000;
    localparam logic [63:0]        ONE_Q62    = 64'h4000_0000_0000_0000;

    // 1/((k+1)(k+2)) in Q0.62, rounded; indexed by k, covers up to 16 terms
    localparam int RECIP_N = 30;
    localparam int RECIP_W = $clog2(RECIP_N);

    typedef logic [63:0] t_recip_tab [RECIP_N];

    localparam t_recip_tab RECIP_TAB = '{
        (ONE_Q62 + 64'd1)   / 64'd2,   (ONE_Q62 + 64'd3)   / 64'd6,
        (ONE_Q62 + 64'd6)   / 64'd12,  (ONE_Q62 + 64'd10)  / 64'd20,
        (ONE_Q62 + 64'd15)  / 64'd30,  (ONE_Q62 + 64'd21)  / 64'd42,
        (ONE_Q62 + 64'd28)  / 64'd56,  (ONE_Q62 + 64'd36)  / 64'd72,
        (ONE_Q62 + 64'd45)  / 64'd90,  (ONE_Q62 + 64'd55)  / 64'd110,
        (ONE_Q62 + 64'd66)  / 64'd132, (ONE_Q62 + 64'd78)  / 64'd156,
        (ONE_Q62 + 64'd91)  / 64'd182, (ONE_Q62 + 64'd105) / 64'd210,
        (ONE_Q62 + 64'd120) / 64'd240, (ONE_Q62 + 64'd136) / 64'd272,
        (ONE_Q62 + 64'd153) / 64'd306, (ONE_Q62 + 64'd171) / 64'd342,
        (ONE_Q62 + 64'd190) / 64'd380, (ONE_Q62 + 64'd210) / 64'd420,
        (ONE_Q62 + 64'd231) / 64'd462, (ONE_Q62 + 64'd253) / 64'd506,
        (ONE_Q62 + 64'd276) / 64'd552, (ONE_Q62 + 64'd300) / 64'd600,
        (ONE_Q62 + 64'd325) / 64'd650, (ONE_Q62 + 64'd351) / 64'd702,
        (ONE_Q62 + 64'd378) / 64'd756, (ONE_Q62 + 64'd406) / 64'd812,
        (ONE_Q62 + 64'd435) / 64'd870, (ONE_Q62 + 64'd465) / 64'd930
    };

    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_FOLD_HI,
        UOP_FOLD_LO,
        UOP_SCALE,
        UOP_MSTART,
        UOP_MPP,
        UOP_MEND,
        UOP_ACCUM,
        UOP_ROUND,
        UOP_NOP
    } t_uop;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_X,
        SRC_X2,
        SRC_TERM,
        SRC_C,
        SRC_RECIP
    } t_src;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_X2,
        DST_C,
        DST_TERM
    } t_dst;

    typedef struct packed {
        t_uop              uop;
        t_src              src_a;
        t_src              src_b;
        logic              shift62;
        logic              negate;
        t_dst              dst;
        logic              jump;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic above_pi;
        logic below_neg_pi;
        logic mul_done;
        logic last_term;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic start;
        logic run;
        logic shift62;
        logic negate;
    } t_mul_ctl;

endpackage

`default_nettype wire

/* src/scs_mul.sv */
// Shared 64x64 signed multiplier built from one 32x32 unit over four partial products.
// Depends on scs_pkg (t_mul_ctl).
`default_nettype none

module scs_mul import scs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_ctl           i_ctl,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_prod,
    output logic               o_done
);

    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [2:0]   r_cnt;
    logic [63:0]  r_p;
    logic [1:0]   r_p_sh;
    logic         r_p_valid;
    logic [127:0] r_acc;

    logic               issue;
    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [1:0]         pp_sh;
    logic [63:0]        pp;
    logic [127:0]       pp_ext;
    logic [62:0]        mag;
    logic signed [63:0] mag_s;

    assign issue = i_ctl.run && !r_cnt[2];

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                op_a  = r_ma[31:0];
                op_b  = r_mb[31:0];
                pp_sh = 2'd0;
            end
            2'd1: begin
                op_a  = r_ma[31:0];
                op_b  = r_mb[63:32];
                pp_sh = 2'd1;
            end
            2'd2: begin
                op_a  = r_ma[63:32];
                op_b  = r_mb[31:0];
                pp_sh = 2'd1;
            end
            default: begin
                op_a  = r_ma[63:32];
                op_b  = r_mb[63:32];
                pp_sh = 2'd2;
            end
        endcase
    end

    assign pp = op_a * op_b;

    always_comb begin
        case (r_p_sh)
            2'd0:    pp_ext = {64'd0, r_p};
            2'd1:    pp_ext = {32'd0, r_p, 32'd0};
            default: pp_ext = {r_p, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 3'd0;
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= issue;
            if (i_ctl.start) begin
                r_cnt <= 3'd0;
            end else if (issue) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_ma  <= i_a[63] ? 64'd0 - i_a : i_a;
            r_mb  <= i_b[63] ? 64'd0 - i_b : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_p_valid) begin
            r_acc <= r_acc + pp_ext;
        end
        if (issue) begin
            r_p    <= pp;
            r_p_sh <= pp_sh;
        end
    end

    // magnitude truncated toward zero, top bit dropped
    assign mag    = i_ctl.shift62 ? r_acc[124:62] : r_acc[121:59];
    assign mag_s  = {1'b0, mag};
    assign o_prod = (r_neg ^ i_ctl.negate) ? 64'sd0 - mag_s : mag_s;
    assign o_done = r_cnt[2];

endmodule

`default_nettype wire

/* src/scs_dpath.sv */
// Datapath: angle folding, series registers, operand routing, rounding and output word register.
// Depends on scs_pkg and scs_mul.
`default_nettype none

module scs_dpath import scs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_uword             i_uword,
    input  logic               i_in_valid,
    input  logic               i_op,
    input  logic signed [31:0] i_angle,
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output logic signed [31:0] o_result,
    output t_status            o_status
);

    localparam logic [63:0] RND_HALF = 64'h0000_0000_1000_0000;
    localparam logic [34:0] SAT_MAG  = 35'h0_8000_0000;

    logic               r_op;
    logic signed [63:0] r_x;
    logic signed [63:0] r_x2;
    logic signed [63:0] r_term;
    logic signed [63:0] r_c;
    logic signed [63:0] r_sum;
    logic [K_W-1:0]     r_k;
    logic [N_W-1:0]     r_n;
    logic               r_out_valid;
    logic               n_out_valid;
    logic signed [31:0] r_result;

    logic               above_pi;
    logic               below_neg_pi;
    logic               last_term;
    logic               out_free;
    logic               mul_done;
    logic               do_round;
    logic signed [63:0] x_scaled;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic signed [63:0] mul_prod;
    logic [63:0]        rnd_mag;
    logic [34:0]        rnd_m;
    logic [31:0]        rnd_sat;
    logic [31:0]        rnd_q;
    t_mul_ctl           mul_ctl;

    assign above_pi     = r_x > PI_Q56;
    assign below_neg_pi = r_x < NEG_PI_Q56;
    assign x_scaled     = {r_x[60:0], 3'b000};
    assign last_term    = r_n == N_W'(NUM_TERMS - 1);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign do_round     = (i_uword.uop == UOP_ROUND) && out_free;

    always_comb begin
        case (i_uword.src_a)
            SRC_X:    mul_a = r_x;
            SRC_X2:   mul_a = r_x2;
            SRC_TERM: mul_a = r_term;
            default:  mul_a = '0;
        endcase
        case (i_uword.src_b)
            SRC_X:     mul_b = r_x;
            SRC_C:     mul_b = r_c;
            SRC_RECIP: mul_b = RECIP_TAB[RECIP_W'(r_k)];
            default:   mul_b = '0;
        endcase
    end

    assign mul_ctl.start   = i_uword.uop == UOP_MSTART;
    assign mul_ctl.run     = i_uword.uop == UOP_MPP;
    assign mul_ctl.shift62 = i_uword.shift62;
    assign mul_ctl.negate  = i_uword.negate;

    scs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    // |sum| + 2^28, the negate's +1 rides on the low bit
    assign rnd_mag = (r_sum[63] ? ~r_sum : r_sum) + (RND_HALF | {63'd0, r_sum[63]});
    assign rnd_m   = rnd_mag[63:29];
    assign rnd_sat = (rnd_m > SAT_MAG) ? SAT_MAG[31:0] : rnd_m[31:0];
    assign rnd_q   = r_sum[63] ? 32'd0 - rnd_sat
                               : (rnd_sat[31] ? 32'h7FFF_FFFF : rnd_sat);

    assign n_out_valid = do_round || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_uword.uop)
            UOP_IDLE: begin
                if (i_in_valid) begin
                    r_op <= i_op;
                    r_x  <= {{2{i_angle[31]}}, i_angle, 30'd0};
                end
            end
            UOP_FOLD_HI: begin
                if (above_pi) begin
                    r_x <= r_x - TWO_PI_Q56;
                end
            end
            UOP_FOLD_LO: begin
                if (below_neg_pi) begin
                    r_x <= r_x + TWO_PI_Q56;
                end
            end
            UOP_SCALE: begin
                r_x    <= x_scaled;
                r_term <= r_op ? ONE_Q59 : x_scaled;
                r_k    <= r_op ? K_W'(0) : K_W'(1);
                r_n    <= '0;
                r_sum  <= '0;
            end
            UOP_MEND: begin
                case (i_uword.dst)
                    DST_X2: r_x2 <= mul_prod;
                    DST_C:  r_c  <= mul_prod;
                    DST_TERM: begin
                        r_term <= mul_prod;
                        r_k    <= r_k + K_W'(2);
                        r_n    <= r_n + N_W'(1);
                    end
                    default: ;
                endcase
            end
            UOP_ACCUM: begin
                r_sum <= r_sum + r_term;
            end
            UOP_ROUND: begin
                if (out_free) begin
                    r_result <= rnd_q;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall = i_uword.uop != UOP_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign o_status.in_valid     = i_in_valid;
    assign o_status.above_pi     = above_pi;
    assign o_status.below_neg_pi = below_neg_pi;
    assign o_status.mul_done     = mul_done;
    assign o_status.last_term    = last_term;
    assign o_status.out_free     = out_free;

endmodule

`default_nettype wire

/* src/scs_useq.sv */
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on scs_pkg (t_uword, t_status, micro-op codes).
`default_nettype none

module scs_useq import scs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_uword
);

    localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_ACCUM = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_ROUND = STEP_W'(14);

    typedef t_uword t_urom [NUM_STEPS];

    localparam t_urom UROM = '{
        '{UOP_IDLE,    SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_FOLD_HI, SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_FOLD_LO, SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_SCALE,   SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_MSTART,  SRC_X,    SRC_X,     1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_MPP,     SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_MEND,    SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_X2,   1'b0, STEP_IDLE},
        '{UOP_ACCUM,   SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_ROUND},
        '{UOP_MSTART,  SRC_X2,   SRC_RECIP, 1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_MPP,     SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_MEND,    SRC_NONE, SRC_NONE,  1'b1, 1'b0, DST_C,    1'b0, STEP_IDLE},
        '{UOP_MSTART,  SRC_TERM, SRC_C,     1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_MPP,     SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_MEND,    SRC_NONE, SRC_NONE,  1'b0, 1'b1, DST_TERM, 1'b1, STEP_ACCUM},
        '{UOP_ROUND,   SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b0, STEP_IDLE},
        '{UOP_NOP,     SRC_NONE, SRC_NONE,  1'b0, 1'b0, DST_NONE, 1'b1, STEP_IDLE}
    };

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] step_inc;
    t_uword            uw;

    assign uw       = UROM[r_step];
    assign step_inc = r_step + STEP_W'(1);

    always_comb begin
        n_step = uw.jump ? uw.target : step_inc;
        case (uw.uop)
            UOP_IDLE: begin
                if (!i_status.in_valid) n_step = r_step;
            end
            UOP_FOLD_HI: begin
                if (i_status.above_pi) n_step = r_step;
            end
            UOP_FOLD_LO: begin
                if (i_status.below_neg_pi) n_step = r_step;
            end
            UOP_MPP: begin
                if (!i_status.mul_done) n_step = r_step;
            end
            UOP_ACCUM: begin
                if (i_status.last_term) n_step = uw.target;
            end
            UOP_ROUND: begin
                n_step = i_status.out_free ? uw.target : r_step;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = uw;

endmodule

`default_nettype wire

/* src/sine_cosine_series.sv */
// Top level of the fixed-point sine/cosine series block.
// Depends on scs_pkg, scs_useq and scs_dpath.
//
//   channel  dir  handshake                  words
//   input    in   i_in_valid / o_in_stall    i_op, i_angle (Q5.26 rad)
//   output   out  o_out_valid / i_out_stall  o_result (Q1.30)
//
// One word in flight from the accepting cycle through the one that loads the result register,
// including up to five 2*pi folding steps; the next word can be taken in the following cycle.
// The shared 32x32 multiplier builds each 64-bit product from four partial products, two per term.
// Reset is synchronous, active low; the first word is taken the cycle after.
// A stalled result holds; the next word is taken and computed meanwhile, then waits to round.
`default_nettype none

module sine_cosine_series import scs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result
);

    t_uword  uword;
    t_status status;

    scs_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uword)
    );

    scs_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (uword),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_angle     (i_angle),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_result    (o_result),
        .o_status    (status)
    );

endmodule

`default_nettype wire

/* src/scs_checker.sv */
// Port-level checks for sine_cosine_series, attached by bind.
// Depends only on the top level's port names.
`default_nettype none

module scs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_result
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##9 o_in_stall)
        else $error("block free again too soon after a word");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word appeared while idle");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_result))
        else $error("output word changed under stall");

endmodule

bind sine_cosine_series scs_checker u_scs_checker (.*);

`default_nettype wire
